// ===== sv/vector_rotate_polar_table_macros.svh =====
// Assertion macros for the vector rotation block
`ifndef VECTOR_ROTATE_POLAR_TABLE_MACROS_SVH
`define VECTOR_ROTATE_POLAR_TABLE_MACROS_SVH

// Check that a condition implies a consequence on the same edge
`define VRP_ASSERT_IMPL(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Check that a condition implies a consequence on the next edge
`define VRP_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== sv/vrp_pkg.sv =====
package vrp_pkg;

  localparam int COORD_BITS_DEF = 15;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int BASE_BITS      = 8;
  localparam int TURN_BITS      = 9;
  localparam int OUT_BITS       = 16;
  localparam int DEG_BITS       = 9;
  localparam int SEARCH_LIMIT   = 32;
  localparam int SEED_DEG       = 21;
  localparam int UPPER_DEG      = 46;
  localparam int LOWER_DEG      = 1;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT_MUL,
    ST_ROOT_DIV,
    ST_ROOT_STEP,
    ST_PHASE_DIV,
    ST_SEARCH_RD,
    ST_SEARCH_EVAL,
    ST_SEARCH_DIV,
    ST_SEARCH_STEP,
    ST_FOLD,
    ST_OUT_RD,
    ST_OUT_MUL,
    ST_OUT_HOLD
  } state_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;
    logic root_mul;
    logic root_div_start;
    logic root_step;
    logic phase_div_start;
    logic search_rd;
    logic search_eval;
    logic search_div_start;
    logic search_step;
    logic fold;
    logic out_rd;
    logic out_mul;
  } cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic div_done;
    logic root_done;
    logic axis_case;
    logic search_stop;
    logic search_final;
  } status_t;

  // Quarter sine, 256 * sin(k deg)
  function automatic logic [8:0] quarter_sine(input logic [6:0] k);
    logic [8:0] v;
    case (k)
      7'd0: v = 9'd0;     7'd1: v = 9'd4;     7'd2: v = 9'd9;     7'd3: v = 9'd13;
      7'd4: v = 9'd18;    7'd5: v = 9'd22;    7'd6: v = 9'd27;    7'd7: v = 9'd31;
      7'd8: v = 9'd36;    7'd9: v = 9'd40;    7'd10: v = 9'd44;   7'd11: v = 9'd49;
      7'd12: v = 9'd53;   7'd13: v = 9'd58;   7'd14: v = 9'd62;   7'd15: v = 9'd66;
      7'd16: v = 9'd71;   7'd17: v = 9'd75;   7'd18: v = 9'd79;   7'd19: v = 9'd83;
      7'd20: v = 9'd88;   7'd21: v = 9'd92;   7'd22: v = 9'd96;   7'd23: v = 9'd100;
      7'd24: v = 9'd104;  7'd25: v = 9'd108;  7'd26: v = 9'd112;  7'd27: v = 9'd116;
      7'd28: v = 9'd120;  7'd29: v = 9'd124;  7'd30: v = 9'd128;  7'd31: v = 9'd132;
      7'd32: v = 9'd136;  7'd33: v = 9'd139;  7'd34: v = 9'd143;  7'd35: v = 9'd147;
      7'd36: v = 9'd150;  7'd37: v = 9'd154;  7'd38: v = 9'd158;  7'd39: v = 9'd161;
      7'd40: v = 9'd165;  7'd41: v = 9'd168;  7'd42: v = 9'd171;  7'd43: v = 9'd175;
      7'd44: v = 9'd178;  7'd45: v = 9'd181;  7'd46: v = 9'd184;  7'd47: v = 9'd187;
      7'd48: v = 9'd190;  7'd49: v = 9'd193;  7'd50: v = 9'd196;  7'd51: v = 9'd199;
      7'd52: v = 9'd202;  7'd53: v = 9'd204;  7'd54: v = 9'd207;  7'd55: v = 9'd210;
      7'd56: v = 9'd212;  7'd57: v = 9'd215;  7'd58: v = 9'd217;  7'd59: v = 9'd219;
      7'd60: v = 9'd222;  7'd61: v = 9'd224;  7'd62: v = 9'd226;  7'd63: v = 9'd228;
      7'd64: v = 9'd230;  7'd65: v = 9'd232;  7'd66: v = 9'd234;  7'd67: v = 9'd236;
      7'd68: v = 9'd237;  7'd69: v = 9'd239;  7'd70: v = 9'd241;  7'd71: v = 9'd242;
      7'd72: v = 9'd243;  7'd73: v = 9'd245;  7'd74: v = 9'd246;  7'd75: v = 9'd247;
      7'd76: v = 9'd248;  7'd77: v = 9'd249;  7'd78: v = 9'd250;  7'd79: v = 9'd251;
      7'd80: v = 9'd252;  7'd81: v = 9'd253;  7'd82: v = 9'd254;  7'd83: v = 9'd254;
      7'd84: v = 9'd255;  7'd85: v = 9'd255;  7'd86: v = 9'd255;  7'd87: v = 9'd256;
      7'd88: v = 9'd256;  7'd89: v = 9'd256;  7'd90: v = 9'd256;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // Full-circle sine entry at the base scale, degree 0..359
  function automatic logic signed [9:0] base_sine(input logic [8:0] d);
    logic [8:0] k;
    logic       neg;
    logic [8:0] m;
    k   = (d >= 9'd180) ? 9'(d - 9'd180) : d;
    neg = (d >= 9'd180);
    m   = (k > 9'd90) ? 9'(9'd180 - k) : k;
    if (neg) begin
      return -$signed({1'b0, quarter_sine(m[6:0])});
    end else begin
      return $signed({1'b0, quarter_sine(m[6:0])});
    end
  endfunction

endpackage

// ===== sv/vrp_div.sv =====
// Restoring divider, one quotient bit a cycle
module vrp_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic [W-1:0] quo,
  output logic         done
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  q;
  logic [W-1:0]  d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    trial;

  assign trial = {rem, q[W-1]};
  assign quo   = q;

  // Shift one numerator bit into the remainder per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        rem  <= '0;
        q    <= num;
        d    <= den;
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= W'(trial - {1'b0, d});
          q   <= {q[W-2:0], 1'b1};
        end else begin
          rem <= trial[W-1:0];
          q   <= {q[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== sv/vrp_ctrl.sv =====
module vrp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic             out_fire,
  input  vrp_pkg::status_t status,
  output vrp_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             out_valid
);
  import vrp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:        if (in_fire) state_next = ST_ROOT_MUL;
      ST_ROOT_MUL:    state_next = ST_ROOT_DIV;
      ST_ROOT_DIV:    if (status.div_done) state_next = ST_ROOT_STEP;
      ST_ROOT_STEP: begin
        if (!status.root_done) begin
          state_next = ST_ROOT_MUL;
        end else if (status.axis_case) begin
          state_next = ST_FOLD;
        end else begin
          state_next = ST_PHASE_DIV;
        end
      end
      ST_PHASE_DIV:   if (status.div_done) state_next = ST_SEARCH_RD;
      ST_SEARCH_RD:   state_next = ST_SEARCH_EVAL;
      ST_SEARCH_EVAL: begin
        if (status.search_stop) begin
          state_next = ST_FOLD;
        end else if (status.search_final) begin
          state_next = ST_FOLD;
        end else begin
          state_next = ST_SEARCH_DIV;
        end
      end
      ST_SEARCH_DIV:  if (status.div_done) state_next = ST_SEARCH_STEP;
      ST_SEARCH_STEP: state_next = ST_SEARCH_RD;
      ST_FOLD:        state_next = ST_OUT_RD;
      ST_OUT_RD:      state_next = ST_OUT_MUL;
      ST_OUT_MUL:     state_next = ST_OUT_HOLD;
      ST_OUT_HOLD:    if (out_fire) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd                  = '0;
    cmd.load             = (state == ST_IDLE) && in_fire;
    cmd.root_mul         = (state == ST_ROOT_MUL);
    cmd.root_div_start   = (state == ST_ROOT_MUL);
    cmd.root_step        = (state == ST_ROOT_STEP);
    cmd.phase_div_start  = (state == ST_ROOT_STEP) && status.root_done && !status.axis_case;
    cmd.search_rd        = (state == ST_SEARCH_RD);
    cmd.search_eval      = (state == ST_SEARCH_EVAL);
    cmd.search_div_start = (state == ST_SEARCH_EVAL) && !status.search_stop
                           && !status.search_final;
    cmd.search_step      = (state == ST_SEARCH_STEP);
    cmd.fold             = (state == ST_FOLD);
    cmd.out_rd           = (state == ST_OUT_RD);
    cmd.out_mul          = (state == ST_OUT_MUL);
    busy                 = (state != ST_IDLE);
    out_valid            = (state == ST_OUT_HOLD);
  end
endmodule

// ===== sv/vrp_datapath.sv =====
module vrp_datapath #(
  parameter int COORD_BITS = vrp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = vrp_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  vrp_pkg::cmd_t                        cmd,
  input  logic signed [COORD_BITS-1:0]         x_in,
  input  logic signed [COORD_BITS-1:0]         y_in,
  input  logic signed [vrp_pkg::TURN_BITS-1:0] turn_degrees,
  output vrp_pkg::status_t                     status,
  output logic signed [vrp_pkg::OUT_BITS-1:0]  x_out,
  output logic signed [vrp_pkg::OUT_BITS-1:0]  y_out
);
  import vrp_pkg::*;

  localparam int AW  = COORD_BITS;          // magnitude bits
  localparam int GW  = COORD_BITS + 2;      // guess bits
  localparam int SQW = 2 * GW;              // square bits
  localparam int SW  = FRAC_BITS + 3;       // signed table entry bits
  localparam int TW  = FRAC_BITS + 2;       // target bits
  localparam int DW  = SQW + 1;             // divider width
  localparam int RW  = COORD_BITS + 1;      // radius bits
  localparam int ITW = $clog2(SEARCH_LIMIT + 1);

  // Scale one table entry to FRAC_BITS, rounding the magnitude when it narrows
  function automatic logic signed [SW-1:0] scaled_sine(input logic [8:0] d);
    logic signed [9:0] b;
    logic [SW+9:0]     m;
    b = base_sine(d);
    m = (SW + 10)'(b[9] ? -b : b);
    if (FRAC_BITS >= BASE_BITS) begin
      m = m << (FRAC_BITS - BASE_BITS);
    end else begin
      m = (m + ((SW + 10)'(1) << (BASE_BITS - 1 - FRAC_BITS))) >> (BASE_BITS - FRAC_BITS);
    end
    return b[9] ? SW'(-m) : SW'(m);
  endfunction

  function automatic logic signed [8:0] clamp_deg(input logic signed [10:0] v);
    if (v < 0) return '0;
    if (v > 11'sd90) return 9'sd90;
    return 9'(v);
  endfunction

  logic signed [COORD_BITS-1:0] px, py;
  logic signed [TURN_BITS-1:0]  turn;
  logic [AW-1:0]                ax, ay;
  logic [SQW-1:0]               sq, g2;
  logic [SQW-1:0]               sq_w;
  logic [GW-1:0]                guess;
  logic [RW-1:0]                rad;
  logic                         root_done;
  logic                         div_start, div_done;
  logic [DW-1:0]                div_num, div_den, div_quo;
  logic [DW-1:0]                num_sel, den_sel;
  logic                         div_neg;
  logic signed [TW-1:0]         target;
  logic signed [8:0]            deg;
  logic signed [SW-1:0]         cur;
  logic signed [SW:0]           err;
  logic signed [SW:0]           den;
  logic [ITW-1:0]               iter;
  logic                         steep;
  logic                         steep_w;
  logic signed [10:0]           total;
  logic [8:0]                   wrap;
  logic signed [SW-1:0]         cos_v, sin_v;
  logic signed [RW+SW:0]        px_prod, py_prod;
  logic signed [9:0]            secant_num;
  logic signed [SW+10:0]        secant_prod;

  // Latch the point and its magnitudes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px    <= x_in;
      py    <= y_in;
      turn  <= turn_degrees;
      ax    <= AW'(x_in[COORD_BITS-1] ? -$signed({1'b0, x_in}) : $signed({1'b0, x_in}));
      ay    <= AW'(y_in[COORD_BITS-1] ? -$signed({1'b0, y_in}) : $signed({1'b0, y_in}));
    end
  end

  // Sum of squares of the latched magnitudes
  assign sq_w    = SQW'(ax) * SQW'(ax) + SQW'(ay) * SQW'(ay);
  assign steep_w = ax < ay;

  // Newton root: sum of squares and guess update
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      guess     <= GW'(AW'(x_in[COORD_BITS-1] ? -x_in : x_in))
                 + GW'(AW'(y_in[COORD_BITS-1] ? -y_in : y_in)) + GW'(1);
      sq        <= '0;
      root_done <= 1'b0;
    end else if (cmd.root_mul) begin
      g2 <= SQW'(guess) * SQW'(guess);
      sq <= sq_w;
    end else if (cmd.root_step) begin
      if (div_quo == '0) begin
        root_done <= 1'b1;
        rad       <= RW'((g2 == sq) ? guess : guess - 1'b1);
      end else begin
        guess <= GW'(guess - div_quo[GW-1:0]);
      end
    end
  end

  // Shared divider operands
  always_comb begin
    num_sel = '0;
    den_sel = '1;
    div_neg = 1'b0;
    if (cmd.root_div_start) begin
      num_sel = DW'(SQW'(SQW'(guess) * SQW'(guess)) - sq_w);
      den_sel = DW'({guess, 1'b0});
    end else if (cmd.phase_div_start) begin
      num_sel = DW'((steep_w ? ax : ay)) << FRAC_BITS;
      den_sel = DW'(rad);
    end else if (cmd.search_div_start) begin
      div_neg = secant_prod[SW+10] ^ den[SW];
      num_sel = DW'(secant_prod[SW+10] ? -secant_prod : secant_prod);
      den_sel = DW'(den[SW] ? -den : den);
    end
  end

  assign div_start = cmd.root_div_start | cmd.phase_div_start | cmd.search_div_start;

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_num <= num_sel;
      div_den <= den_sel;
    end
  end

  logic div_go, neg_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      div_go <= 1'b0;
    end else begin
      div_go <= div_start;
    end
    if (div_start) neg_q <= div_neg;
  end

  vrp_div #(.W(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  // Secant numerator and error terms
  always_comb begin
    if (err > (SW+1)'(4)) begin
      secant_num = 10'(10'(UPPER_DEG) - 10'(deg));
      den        = (SW+1)'(scaled_sine(9'(UPPER_DEG))) - (SW+1)'(cur);
    end else begin
      secant_num = 10'(10'(LOWER_DEG) - 10'(deg));
      den        = (SW+1)'(cur) - (SW+1)'(scaled_sine(9'(LOWER_DEG)));
    end
    secant_prod = (SW+11)'(secant_num) * (SW+11)'(err);
  end

  // Search: stop, one-degree nudge (also when the divisor is zero), or secant step
  logic nudge;
  assign nudge = (err >= -(SW+1)'(4) && err <= (SW+1)'(4)) || den == '0;
  assign status.search_stop  = (err >= -(SW+1)'(2) && err <= (SW+1)'(2)) ||
                               (iter == ITW'(SEARCH_LIMIT));
  assign status.search_final = nudge;

  logic signed [9:0] step_q;
  always_comb begin
    step_q = neg_q ? -$signed(10'(div_quo)) : $signed(10'(div_quo));
  end

  always_ff @(posedge clk) begin
    if (cmd.phase_div_start) begin
      steep <= steep_w;
    end
    if (cmd.root_step && root_done == 1'b0 && div_quo == '0) begin
      deg  <= 9'(SEED_DEG);
      iter <= '0;
    end
    if (cmd.search_rd) begin
      cur <= scaled_sine(9'(deg));
    end
    if (cmd.search_eval) begin
      if (!status.search_stop && nudge) begin
        if (err > 0) deg <= deg + 9'sd1;
        else         deg <= deg - 9'sd1;
      end
      if (!status.search_stop) iter <= iter + 1'b1;
    end
    if (cmd.search_step) begin
      if (err > (SW+1)'(4)) begin
        deg <= clamp_deg(11'(deg) + 11'(step_q));
      end else begin
        deg <= clamp_deg(11'(deg) - 11'(step_q));
      end
    end
  end

  // Target captured when the phase division finishes
  logic phase_pend;
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_pend <= 1'b0;
    end else begin
      if (cmd.phase_div_start) phase_pend <= 1'b1;
      else if (div_done) phase_pend <= 1'b0;
    end
    if (phase_pend && div_done) target <= TW'(div_quo);
  end

  assign err = (SW+1)'(target) - (SW+1)'(cur);

  // Axis cases, quadrant fold and wrap
  assign status.axis_case = (px == '0) || (py == '0);
  assign status.div_done  = div_done;
  assign status.root_done = root_done;

  logic signed [10:0] phase;
  always_comb begin
    if (px == '0 && py == '0) begin
      phase = '0;
    end else if (px == '0) begin
      phase = py[COORD_BITS-1] ? -11'sd90 : 11'sd90;
    end else if (py == '0) begin
      phase = px[COORD_BITS-1] ? 11'sd180 : 11'sd0;
    end else begin
      phase = 11'(deg);
      if (steep) phase = 11'sd90 - phase;
      if (px[COORD_BITS-1]) phase = 11'sd180 - phase;
      if (py[COORD_BITS-1]) phase = -phase;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fold) begin
      total <= 11'(turn) + phase;
    end
  end

  always_comb begin
    logic signed [10:0] t;
    t = total;
    if (t < 0) t = t + 11'sd360;
    if (t < 0) t = t + 11'sd360;
    if (t >= 11'sd360) t = t - 11'sd360;
    wrap = 9'(t);
  end

  // Products of radius and table entries
  assign px_prod = $signed({1'b0, rad}) * cos_v;
  assign py_prod = $signed({1'b0, rad}) * sin_v;

  // Table lookups and floor shift
  always_ff @(posedge clk) begin
    if (cmd.out_rd) begin
      sin_v <= scaled_sine(wrap);
      cos_v <= scaled_sine((wrap >= 9'd270) ? 9'(wrap - 9'd270) : 9'(wrap + 9'd90));
    end
    if (cmd.out_mul) begin
      x_out <= OUT_BITS'(px_prod >>> FRAC_BITS);
      y_out <= OUT_BITS'(py_prod >>> FRAC_BITS);
    end
  end
endmodule

// ===== sv/vector_rotate_polar_table.sv =====
// Channel | Dir | Fields (lowest bits first)
// s_axis  | in  | tdata: x_in[14:0], y_in[29:15], turn_degrees[38:30], zero pad to 40
// m_axis  | out | tdata: x_out[15:0], y_out[31:16]
// One point at a time. The serial divider is shared by each Newton pass, the phase ratio
// and each secant step; an axis point skips the phase ratio and the secant search.
// s_axis_tready is high only when idle; the result holds until taken. rst is synchronous.
module vector_rotate_polar_table #(
  parameter int COORD_BITS = vrp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = vrp_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // x_in, y_in, turn_degrees
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // x_out, y_out
);
  import vrp_pkg::*;
  `include "vector_rotate_polar_table_macros.svh"

  cmd_t    cmd;
  status_t status;
  logic    busy, in_fire, out_fire;
  logic signed [OUT_BITS-1:0] x_out, y_out;

  assign s_axis_tready = !busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {y_out, x_out};

  vrp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .out_fire  (out_fire),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (m_axis_tvalid)
  );

  vrp_datapath #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .x_in         (s_axis_tdata[COORD_BITS-1:0]),
    .y_in         (s_axis_tdata[15 +: COORD_BITS]),
    .turn_degrees (s_axis_tdata[38:30]),
    .status       (status),
    .x_out        (x_out),
    .y_out        (y_out)
  );

  `VRP_ASSERT_IMPL(a_no_accept_busy, clk, rst, m_axis_tvalid, !s_axis_tready, "input open")
  `VRP_ASSERT_NEXT(a_load_starts, clk, rst, in_fire, busy, "transaction not started")
  `VRP_ASSERT_NEXT(a_result_frees, clk, rst, out_fire, s_axis_tready, "not idle after result")
endmodule

// ===== sim/tb_top.sv =====
module tb_top;

  import vrp_pkg::*;

  localparam int CLK_HALF   = 10;
  localparam int N_RANDOM   = 1430;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_WAIT  = 200;

  // Idling phases
  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} idle_phase_t;

  typedef struct packed {
    logic signed [8:0]  turn;
    logic signed [14:0] py;
    logic signed [14:0] px;
  } point_t;

  typedef struct packed {
    logic signed [15:0] ry;
    logic signed [15:0] rx;
  } rotated_t;

  typedef struct {
    point_t   pt;
    logic     known;
    rotated_t res;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  vector_rotate_polar_table dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  int        sine_lut [360];
  rotated_t  pending_rotations [$];
  int        n_mismatch;
  int        idle_cycles;
  idle_phase_t phase;
  bit        hold_off;
  bit        stim_done;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Build the full-circle sine table at 256 scale
  function automatic int quarter_val(int k);
    int q [91] = '{0, 4, 9, 13, 18, 22, 27, 31, 36, 40,
      44, 49, 53, 58, 62, 66, 71, 75, 79, 83, 88, 92, 96, 100, 104, 108, 112, 116, 120, 124,
      128, 132, 136, 139, 143, 147, 150, 154, 158, 161, 165, 168, 171, 175, 178, 181, 184,
      187, 190, 193, 196, 199, 202, 204, 207, 210, 212, 215, 217, 219, 222, 224, 226, 228,
      230, 232, 234, 236, 237, 239, 241, 242, 243, 245, 246, 247, 248, 249, 250, 251,
      252, 253, 254, 254, 255, 255, 255, 256, 256, 256, 256};
    return q[k];
  endfunction

  initial begin
    for (int k = 0; k <= 90; k++) begin
      sine_lut[k] = quarter_val(k);
      sine_lut[180 - k] = quarter_val(k);
      sine_lut[(180 + k) % 360] = -quarter_val(k);
      sine_lut[(360 - k) % 360] = -quarter_val(k);
    end
    sine_lut[0] = 0;
    sine_lut[180] = 0;
  end

  function automatic longint isqrt_floor(longint ax, longint ay);
    longint sq, g, g2, stp;
    sq = ax * ax + ay * ay;
    g = ax + ay + 1;
    forever begin
      g2 = g * g;
      stp = (g2 - sq) / (2 * g);
      if (stp == 0) break;
      g -= stp;
    end
    return (g2 == sq) ? g : g - 1;
  endfunction

  // Angle of the point in degrees, secant search on the smaller leg
  function automatic int point_angle(int px, int py, longint rad);
    int ax, ay, sm, deg, cur, err, den, iter, target;
    bit steep;
    ax = (px < 0) ? -px : px;
    ay = (py < 0) ? -py : py;
    if (px == 0 && py == 0) return 0;
    if (px == 0) return (py >= 0) ? 90 : -90;
    if (py == 0) return (px >= 0) ? 0 : 180;
    steep = ax < ay;
    sm = steep ? ax : ay;
    target = int'((longint'(sm) << 8) / rad);
    iter = 0;
    deg = 21;
    cur = sine_lut[21];
    err = target - cur;
    while ((err < -2 || err > 2) && iter < 32) begin
      iter++;
      if (err > 4) begin
        den = sine_lut[46] - cur;
        if (den == 0) begin deg++; break; end
        deg += ((46 - deg) * err) / den;
      end else if (err < -4) begin
        den = cur - sine_lut[1];
        if (den == 0) begin deg--; break; end
        deg -= ((1 - deg) * err) / den;
      end else if (err < 0) begin
        deg--;
        break;
      end else begin
        deg++;
        break;
      end
      if (deg < 0) deg = 0;
      if (deg > 90) deg = 90;
      cur = sine_lut[deg];
      err = target - cur;
    end
    if (steep) deg = 90 - deg;
    if (px < 0) deg = 180 - deg;
    if (py < 0) deg = -deg;
    return deg;
  endfunction

  function automatic rotated_t rotate_point(point_t p);
    int px, py, tot, w;
    longint rad, xo, yo;
    rotated_t r;
    px = p.px;
    py = p.py;
    rad = isqrt_floor((px < 0) ? -px : px, (py < 0) ? -py : py);
    tot = int'(p.turn) + point_angle(px, py, rad);
    w = tot % 360;
    if (w < 0) w += 360;
    xo = (rad * sine_lut[(w + 90) % 360]) >>> 8;
    yo = (rad * sine_lut[w]) >>> 8;
    r.rx = xo[15:0];
    r.ry = yo[15:0];
    return r;
  endfunction

  // Offer one transaction and hold until accepted
  task automatic send_point(point_t p);
    if (phase == PH_SEND_IDLE || phase == PH_BOTH) begin
      while ($urandom_range(99) < ((phase == PH_BOTH) ? 34 : 51)) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tdata  <= {1'b0, p};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_rotations.push_back(rotate_point(p));
  endtask

  // Drop the offer and wait for every outstanding result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_rotations.size() != 0) @(posedge clk);
  endtask

  function automatic point_t rand_point();
    point_t p;
    int mode;
    mode = $urandom_range(9);
    p.px = 15'($urandom);
    p.py = 15'($urandom);
    p.turn = 9'($urandom);
    if (mode == 0) p.px = 0;
    if (mode == 1) p.py = 0;
    if (mode == 2) begin
      p.px = $signed(15'($urandom_range(40))) - 15'sd20;
      p.py = $signed(15'($urandom_range(40))) - 15'sd20;
    end
    if (mode == 3) p.py = p.px;
    return p;
  endfunction

  // Receiver: stall per phase, long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (phase == PH_RECV_STALL) begin
      m_axis_tready <= ($urandom_range(99) >= 51);
    end else if (phase == PH_BOTH) begin
      m_axis_tready <= ($urandom_range(99) >= 34);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    rotated_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_rotations.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("Unexpected result x=%0d y=%0d", got.rx, got.ry);
      end else begin
        want = pending_rotations.pop_front();
        if (got.rx !== want.rx || got.ry !== want.ry) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("Mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                     want.rx, want.ry, got.rx, got.ry);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    automatic stim_row_t rows [$] = '{
      '{'{9'sd0, 15'sd0, 15'sd0}, 1'b1, '{16'sd0, 16'sd0}},
      '{'{9'sd90, 15'sd0, 15'sd0}, 1'b1, '{16'sd0, 16'sd0}},
      '{'{9'sd0, 15'sd0, 15'sd100}, 1'b1, '{16'sd0, 16'sd100}},
      '{'{9'sd90, 15'sd0, 15'sd100}, 1'b1, '{16'sd100, 16'sd0}},
      '{'{9'sd0, 15'sd100, 15'sd0}, 1'b1, '{16'sd100, 16'sd0}},
      '{'{9'sd0, -15'sd100, 15'sd0}, 1'b1, '{-16'sd100, 16'sd0}},
      '{'{9'sd0, 15'sd0, -15'sd100}, 1'b1, '{16'sd0, -16'sd100}},
      '{'{9'sd180, 15'sd0, 15'sd100}, 1'b1, '{16'sd0, -16'sd100}},
      '{'{-9'sd180, 15'sd0, 15'sd100}, 1'b1, '{16'sd0, -16'sd100}},
      '{'{9'sd0, 15'sd0, 15'sd16383}, 1'b0, '0},
      '{'{9'sd0, 15'sd0, 15'sh4000}, 1'b0, '0},
      '{'{9'sd45, 15'sd16383, 15'sd16383}, 1'b0, '0},
      '{'{9'sh100, 15'sh4000, 15'sh4000}, 1'b0, '0},
      '{'{9'sd255, 15'sd16383, 15'sh4000}, 1'b0, '0},
      '{'{9'sd0, 15'sd4, 15'sd3}, 1'b0, '0},
      '{'{9'sd30, 15'sd1, 15'sd1}, 1'b0, '0},
      '{'{9'sd0, 15'sd1, 15'sd16383}, 1'b0, '0},
      '{'{9'sd0, 15'sd16383, 15'sd1}, 1'b0, '0},
      '{'{-9'sd1, -15'sd3, 15'sd5}, 1'b0, '0},
      '{'{9'sd7, 15'sd12, -15'sd5}, 1'b0, '0}
    };
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    n_mismatch = 0;
    phase = PH_FREE;
    hold_off = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    foreach (rows[i]) begin
      send_point(rows[i].pt);
      if (rows[i].known && rows[i].res !== pending_rotations[$]) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("Table row %0d disagrees with prediction", i);
      end
    end
    drain_results();

    // Random points across idling phases
    for (int i = 0; i < N_RANDOM; i++) begin
      phase = idle_phase_t'((i * 4) / N_RANDOM);
      if (i == 100) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      if (i == 700) drain_results();
      send_point(rand_point());
    end

    drain_results();
    repeat (TAIL_WAIT) @(posedge clk);
    if (n_mismatch == 0 && pending_rotations.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/vrp_pkg.sv
sv/vrp_div.sv
sv/vrp_ctrl.sv
sv/vrp_datapath.sv
sv/vector_rotate_polar_table.sv
sim/tb_top.sv
